### design/wavelet_generator_macros.svh
// assertion macros used by the wavelet generator top level
`ifndef WAVELET_GENERATOR_MACROS_SVH
`define WAVELET_GENERATOR_MACROS_SVH

// same-cycle implication, disabled while in reset
`define WG_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define WG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/wg_pkg.sv
// shared types and constants of the wavelet generator
package wg_pkg;

    // fixed-point constants
    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [28:0] EINV_Q30 = 29'd395007542;
    localparam logic [30:0] ONE_Q30  = 31'h4000_0000;

    // shared multiplier geometry
    localparam int MUL_AW = 40;
    localparam int MUL_BW = 32;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // shared divider geometry, numerator left aligned
    localparam int DIV_NW = 64;
    localparam int DIV_DW = 40;
    localparam int DIV_SW = 7;

    // wavelet kinds
    localparam logic KIND_GAUSS  = 1'b0;
    localparam logic KIND_RICKER = 1'b1;

    typedef enum logic [1:0] {
        NORM_NONE = 2'd0,
        NORM_PEAK = 2'd1,
        NORM_AREA = 2'd2,
        NORM_RSVD = 2'd3
    } norm_mode_t;

    typedef struct packed {
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
        logic [DIV_SW-1:0] steps;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DIV_NW-1:0] quo;
    } div_rsp_t;

endpackage

### design/wg_req_if.sv
// request channel of the wavelet generator
interface wg_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic [6:0]  sample_count;
    logic [31:0] sample_interval;
    logic [31:0] shape_width;
    logic [1:0]  norm_mode;

    modport source (output valid, req_type, sample_count, sample_interval, shape_width,
                    norm_mode, input ready);
    modport sink (input valid, req_type, sample_count, sample_interval, shape_width,
                  norm_mode, output ready);
endinterface

### design/wg_res_if.sv
// result channel of the wavelet generator
interface wg_res_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sample_value;
    logic [5:0]         sample_index;
    logic               last;
    logic               error;

    modport source (output valid, sample_value, sample_index, last, error, input ready);
    modport sink (input valid, sample_value, sample_index, last, error, output ready);
endinterface

### design/wg_mul.sv
// shared unsigned multiplier with registered product
module wg_mul (
    input  logic                      clk,
    input  wg_pkg::mul_req_t          req,
    output logic [wg_pkg::MUL_PW-1:0] prod
);
    import wg_pkg::*;

    logic [MUL_PW-1:0] prod_reg;

    // product registered, available in the cycle after the operands
    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_PW'(req.a) * MUL_PW'(req.b);
    end

    assign prod = prod_reg;
endmodule

### design/wg_div.sv
// shared restoring divider, one quotient bit per cycle
module wg_div (
    input  logic             clk,
    input  logic             rst_n,
    input  wg_pkg::div_req_t req,
    output wg_pkg::div_rsp_t rsp
);
    import wg_pkg::*;

    logic [DIV_NW-1:0] num_reg;
    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] den_reg;
    logic [DIV_SW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_DW:0]   rem_sh;
    logic [DIV_DW:0]   rem_dif;
    logic              fits;

    // one trial subtraction
    assign rem_sh  = {rem_reg, num_reg[DIV_NW-1]};
    assign rem_dif = rem_sh - {1'b0, den_reg};
    assign fits    = (rem_sh >= {1'b0, den_reg});

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_SW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= req.num;
            den_reg <= req.den;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_NW-2:0], 1'b0};
            rem_reg <= fits ? rem_dif[DIV_DW-1:0] : rem_sh[DIV_DW-1:0];
            quo_reg <= {quo_reg[DIV_NW-2:0], fits};
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;
endmodule

### design/wavelet_generator.sv
// top level: gaussian and ricker wavelet generator with its sequencer
//
// A request on req (valid/ready) names a wavelet kind, a sample count, a
// sample interval, a shape width and a normalization mode. Results leave on
// res (valid/ready), one transaction per sample in index order, with last on
// the final one. Ricker with area normalization yields one error transaction.
// The block takes one request at a time: req.ready is high only while the
// sequencer is idle and the output register is free or being drained.
// Samples are computed one after another on one registered multiplier and
// one restoring divider (one quotient bit per cycle). A nonzero sample needs
// twelve 31-step divisions in the exponential series, up to 31 scaling
// multiplies, and for gaussian one 61-step division for the argument.
// Normalized output adds a 62-step division per sample. The error result
// is loaded in the cycle the request is taken.
// A stalled receiver holds the output register; the sequencer waits.
// Reset returns the sequencer to idle and empties the output register;
// the sample store needs no clearing.
`include "wavelet_generator_macros.svh"

module wavelet_generator #(
    parameter int MAX_SAMPLES = 64
) (
    input  logic clk,
    input  logic rst_n,
    wg_req_if.sink   req,
    wg_res_if.source res
);
    import wg_pkg::*;

    localparam int          IW    = $clog2(MAX_SAMPLES);
    localparam logic [6:0]  MAX_N = 7'(MAX_SAMPLES);

    typedef enum logic [28:0] {
        S_IDLE   = 29'b1 << 0,
        S_TT     = 29'b1 << 1,
        S_TT2    = 29'b1 << 2,
        S_GDIV   = 29'b1 << 3,
        S_GSQ    = 29'b1 << 4,
        S_GSQ2   = 29'b1 << 5,
        S_RHI    = 29'b1 << 6,
        S_RLO    = 29'b1 << 7,
        S_RV     = 29'b1 << 8,
        S_RU     = 29'b1 << 9,
        S_RU2    = 29'b1 << 10,
        S_RA     = 29'b1 << 11,
        S_RA2    = 29'b1 << 12,
        S_EXP0   = 29'b1 << 13,
        S_EMUL   = 29'b1 << 14,
        S_EDIV   = 29'b1 << 15,
        S_EWAIT  = 29'b1 << 16,
        S_ECLAMP = 29'b1 << 17,
        S_EK     = 29'b1 << 18,
        S_EK2    = 29'b1 << 19,
        S_EDONE  = 29'b1 << 20,
        S_RF2    = 29'b1 << 21,
        S_STORE  = 29'b1 << 22,
        S_NORM0  = 29'b1 << 23,
        S_NORM1  = 29'b1 << 24,
        S_RD     = 29'b1 << 25,
        S_RDW    = 29'b1 << 26,
        S_NDIV   = 29'b1 << 27,
        S_EMIT   = 29'b1 << 28
    } state_t;

    // control registers
    state_t            state_reg, state_next;
    logic [6:0]        i_reg, i_next;
    logic              out_vld_reg, out_vld_next;
    logic [39:0]       sum_reg, sum_next;

    // request and working registers
    logic              kind_reg, kind_next;
    logic [6:0]        n_reg, n_next;
    logic [31:0]       dt_reg, dt_next;
    logic [31:0]       w_reg, w_next;
    norm_mode_t        mode_reg, mode_next;
    logic [37:0]       tt_reg, tt_next;
    logic [53:0]       tmp_reg, tmp_next;
    logic [45:0]       x_reg, x_next;
    logic [4:0]        k_reg, k_next;
    logic [31:0]       g_reg, g_next;
    logic [30:0]       term_reg, term_next;
    logic signed [33:0] acc_reg, acc_next;
    logic [3:0]        j_reg, j_next;
    logic [30:0]       e_reg, e_next;
    logic [31:0]       smp_reg, smp_next;
    logic              nneg_reg, nneg_next;
    logic [39:0]       nmag_reg, nmag_next;

    // output register
    logic [31:0]       oval_reg, oval_next;
    logic [5:0]        oidx_reg, oidx_next;
    logic              olast_reg, olast_next;
    logic              oerr_reg, oerr_next;

    // sample store
    logic [31:0]       mem [MAX_SAMPLES];
    logic [31:0]       rd_reg;
    logic [IW-1:0]     raddr;
    logic              we;

    // shared units
    mul_req_t          mul_req;
    logic [MUL_PW-1:0] mul_p;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // helpers
    logic [7:0]        two_i, nm1;
    logic [6:0]        absk;
    logic [6:0]        cnt_in;
    logic              out_free;
    logic [70:0]       vsum;
    logic [60:0]       ek_sum;
    logic [47:0]       f_val;
    logic [47:0]       f_mag;
    logic [31:0]       mag32;
    logic [31:0]       s_abs;
    logic              q_neg;
    logic [31:0]       q_val;

    wg_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_p)
    );

    wg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // time offset |2i-(n-1)| in half intervals
    assign two_i = {i_reg, 1'b0};
    assign nm1   = {1'b0, n_reg} - 8'd1;
    assign absk  = (two_i >= nm1) ? 7'(two_i - nm1) : 7'(nm1 - two_i);

    assign cnt_in   = req.sample_count;
    assign out_free = !out_vld_reg || res.ready;
    assign req.ready = (state_reg == S_IDLE) && out_free;

    // ricker nu*|t| recombination and exp scaling round
    assign vsum   = {1'b0, tmp_reg, 16'b0} + 71'(mul_p[53:0]);
    assign ek_sum = 61'(mul_p[59:0]) + 61'h2000_0000;

    // ricker polynomial factor 1 - 2a
    assign f_val = 48'h1_0000_0000 - {1'b0, x_reg, 1'b0};
    assign f_mag = f_val[47] ? (~f_val + 48'd1) : f_val;
    assign mag32 = mul_p[55:24];

    // normalization quotient sign and saturation
    assign s_abs = rd_reg[31] ? (~rd_reg + 32'd1) : rd_reg;
    assign q_neg = rd_reg[31] != nneg_reg;
    always_comb
    begin
        if (q_neg)
        begin
            q_val = (div_rsp.quo >= 64'h8000_0000) ? 32'h8000_0000
                                                     : (~div_rsp.quo[31:0] + 32'd1);
        end
        else
        begin
            q_val = (div_rsp.quo >= 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : div_rsp.quo[31:0];
        end
    end

    // store access
    assign we    = (state_reg == S_STORE);
    assign raddr = (state_reg == S_NORM0) ? IW'(n_reg >> 1) : IW'(i_reg);

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[IW'(i_reg)] <= smp_reg;
        end
        rd_reg <= mem[raddr];
    end

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        i_next       = i_reg;
        out_vld_next = out_vld_reg && !res.ready;
        sum_next     = sum_reg;
        kind_next    = kind_reg;
        n_next       = n_reg;
        dt_next      = dt_reg;
        w_next       = w_reg;
        mode_next    = mode_reg;
        tt_next      = tt_reg;
        tmp_next     = tmp_reg;
        x_next       = x_reg;
        k_next       = k_reg;
        g_next       = g_reg;
        term_next    = term_reg;
        acc_next     = acc_reg;
        j_next       = j_reg;
        e_next       = e_reg;
        smp_next     = smp_reg;
        nneg_next    = nneg_reg;
        nmag_next    = nmag_reg;
        oval_next    = oval_reg;
        oidx_next    = oidx_reg;
        olast_next   = olast_reg;
        oerr_next    = oerr_reg;
        mul_req      = '0;
        div_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid && req.ready)
                begin
                    kind_next = req.req_type;
                    dt_next   = req.sample_interval;
                    w_next    = req.shape_width;
                    if (cnt_in == 7'd0)
                        n_next = 7'd1;
                    else if (cnt_in > MAX_N)
                        n_next = MAX_N;
                    else
                        n_next = cnt_in;
                    mode_next = (norm_mode_t'(req.norm_mode) == NORM_RSVD)
                                ? NORM_NONE : norm_mode_t'(req.norm_mode);
                    if (req.req_type == KIND_RICKER &&
                        norm_mode_t'(req.norm_mode) == NORM_AREA)
                    begin
                        out_vld_next = 1'b1;
                        oval_next    = '0;
                        oidx_next    = '0;
                        olast_next   = 1'b1;
                        oerr_next    = 1'b1;
                    end
                    else
                    begin
                        sum_next   = '0;
                        i_next     = '0;
                        state_next = S_TT;
                    end
                end
            end
            S_TT:
            begin
                mul_req.a  = MUL_AW'(absk);
                mul_req.b  = dt_reg;
                state_next = S_TT2;
            end
            S_TT2:
            begin
                tt_next = mul_p[37:0];
                if (kind_reg == KIND_RICKER)
                    state_next = S_RHI;
                else if (w_reg == 32'd0)
                begin
                    // zero sigma: only the sample at t = 0 survives
                    if (mul_p[37:0] == 38'd0)
                    begin
                        x_next     = '0;
                        state_next = S_EXP0;
                    end
                    else
                    begin
                        smp_next   = '0;
                        state_next = S_STORE;
                    end
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {mul_p[37:0], 26'b0};
                    div_req.den   = DIV_DW'(w_reg);
                    div_req.steps = DIV_SW'(61);
                    state_next    = S_GDIV;
                end
            end
            S_GDIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quo >= (64'd6 << 24))
                    begin
                        smp_next   = '0;
                        state_next = S_STORE;
                    end
                    else
                        state_next = S_GSQ;
                end
            end
            S_GSQ:
            begin
                mul_req.a  = MUL_AW'(div_rsp.quo[26:0]);
                mul_req.b  = MUL_BW'(div_rsp.quo[26:0]);
                state_next = S_GSQ2;
            end
            S_GSQ2:
            begin
                x_next     = 46'(mul_p[53:16]);
                state_next = S_EXP0;
            end
            S_RHI:
            begin
                mul_req.a  = MUL_AW'(tt_reg);
                mul_req.b  = MUL_BW'(w_reg[31:16]);
                state_next = S_RLO;
            end
            S_RLO:
            begin
                tmp_next   = mul_p[53:0];
                mul_req.a  = MUL_AW'(tt_reg);
                mul_req.b  = MUL_BW'(w_reg[15:0]);
                state_next = S_RV;
            end
            S_RV:
            begin
                tmp_next = vsum[70:17];
                if (|vsum[70:53])
                begin
                    smp_next   = '0;
                    state_next = S_STORE;
                end
                else
                    state_next = S_RU;
            end
            S_RU:
            begin
                mul_req.a  = MUL_AW'(tmp_reg[35:8]);
                mul_req.b  = PI_Q30;
                state_next = S_RU2;
            end
            S_RU2:
            begin
                tmp_next   = 54'(mul_p[60:30]);
                state_next = S_RA;
            end
            S_RA:
            begin
                mul_req.a  = MUL_AW'(tmp_reg[30:0]);
                mul_req.b  = MUL_BW'(tmp_reg[30:0]);
                state_next = S_RA2;
            end
            S_RA2:
            begin
                x_next     = mul_p[61:16];
                state_next = S_EXP0;
            end
            S_EXP0:
            begin
                // exp(-x) vanishes from 32.0 up
                if (|x_reg[45:37])
                begin
                    e_next     = '0;
                    state_next = S_EDONE;
                end
                else
                begin
                    k_next     = x_reg[36:32];
                    g_next     = x_reg[31:0];
                    acc_next   = 34'sd1073741824;
                    term_next  = ONE_Q30;
                    j_next     = 4'd1;
                    state_next = S_EMUL;
                end
            end
            S_EMUL:
            begin
                mul_req.a  = MUL_AW'(term_reg);
                mul_req.b  = g_reg;
                state_next = S_EDIV;
            end
            S_EDIV:
            begin
                div_req.start = 1'b1;
                div_req.num   = {mul_p[62:32], 33'b0};
                div_req.den   = DIV_DW'(j_reg);
                div_req.steps = DIV_SW'(31);
                state_next    = S_EWAIT;
            end
            S_EWAIT:
            begin
                if (div_rsp.done)
                begin
                    term_next = div_rsp.quo[30:0];
                    if (j_reg[0])
                        acc_next = acc_reg - $signed({3'b0, div_rsp.quo[30:0]});
                    else
                        acc_next = acc_reg + $signed({3'b0, div_rsp.quo[30:0]});
                    if (j_reg == 4'd12)
                        state_next = S_ECLAMP;
                    else
                    begin
                        j_next     = j_reg + 4'd1;
                        state_next = S_EMUL;
                    end
                end
            end
            S_ECLAMP:
            begin
                if (acc_reg[33])
                    e_next = '0;
                else if (acc_reg > 34'sd1073741824)
                    e_next = ONE_Q30;
                else
                    e_next = acc_reg[30:0];
                state_next = S_EK;
            end
            S_EK:
            begin
                // scale by e^-1 once per integer unit of x
                if (k_reg == 5'd0)
                    state_next = S_EDONE;
                else
                begin
                    mul_req.a  = MUL_AW'(e_reg);
                    mul_req.b  = MUL_BW'(EINV_Q30);
                    state_next = S_EK2;
                end
            end
            S_EK2:
            begin
                e_next     = ek_sum[60:30];
                k_next     = k_reg - 5'd1;
                state_next = S_EK;
            end
            S_EDONE:
            begin
                if (kind_reg == KIND_GAUSS)
                begin
                    smp_next   = 32'(e_reg);
                    state_next = S_STORE;
                end
                else if (e_reg == 31'd0)
                begin
                    smp_next   = '0;
                    state_next = S_STORE;
                end
                else
                begin
                    mul_req.a  = MUL_AW'(f_mag[38:8]);
                    mul_req.b  = MUL_BW'(e_reg);
                    state_next = S_RF2;
                end
            end
            S_RF2:
            begin
                smp_next   = f_val[47] ? (~mag32 + 32'd1) : mag32;
                state_next = S_STORE;
            end
            S_STORE:
            begin
                if (kind_reg == KIND_GAUSS)
                    sum_next = sum_reg + 40'(smp_reg);
                if (i_reg == n_reg - 7'd1)
                begin
                    i_next     = '0;
                    state_next = S_NORM0;
                end
                else
                begin
                    i_next     = i_reg + 7'd1;
                    state_next = S_TT;
                end
            end
            S_NORM0:
            begin
                state_next = S_NORM1;
            end
            S_NORM1:
            begin
                if (mode_reg == NORM_PEAK)
                begin
                    nneg_next = rd_reg[31];
                    nmag_next = 40'(s_abs);
                end
                else
                begin
                    nneg_next = 1'b0;
                    nmag_next = sum_reg;
                end
                state_next = S_RD;
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            S_RDW:
            begin
                if (mode_reg == NORM_NONE)
                begin
                    smp_next   = rd_reg;
                    state_next = S_EMIT;
                end
                else if (s_abs == 32'd0)
                begin
                    smp_next   = '0;
                    state_next = S_EMIT;
                end
                else if (nmag_reg == 40'd0)
                begin
                    smp_next   = q_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
                    state_next = S_EMIT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    div_req.num   = {s_abs, 32'b0};
                    div_req.den   = nmag_reg;
                    div_req.steps = DIV_SW'(62);
                    state_next    = S_NDIV;
                end
            end
            S_NDIV:
            begin
                if (div_rsp.done)
                begin
                    smp_next   = q_val;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_vld_next = 1'b1;
                    oval_next    = smp_reg;
                    oidx_next    = 6'(i_reg);
                    olast_next   = (i_reg == n_reg - 7'd1);
                    oerr_next    = 1'b0;
                    if (i_reg == n_reg - 7'd1)
                        state_next = S_IDLE;
                    else
                    begin
                        i_next     = i_reg + 7'd1;
                        state_next = S_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            i_reg       <= '0;
            out_vld_reg <= 1'b0;
            sum_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            i_reg       <= i_next;
            out_vld_reg <= out_vld_next;
            sum_reg     <= sum_next;
        end
    end

    // working and output payload
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        n_reg     <= n_next;
        dt_reg    <= dt_next;
        w_reg     <= w_next;
        mode_reg  <= mode_next;
        tt_reg    <= tt_next;
        tmp_reg   <= tmp_next;
        x_reg     <= x_next;
        k_reg     <= k_next;
        g_reg     <= g_next;
        term_reg  <= term_next;
        acc_reg   <= acc_next;
        j_reg     <= j_next;
        e_reg     <= e_next;
        smp_reg   <= smp_next;
        nneg_reg  <= nneg_next;
        nmag_reg  <= nmag_next;
        oval_reg  <= oval_next;
        oidx_reg  <= oidx_next;
        olast_reg <= olast_next;
        oerr_reg  <= oerr_next;
    end

    assign res.valid        = out_vld_reg;
    assign res.sample_value = $signed(oval_reg);
    assign res.sample_index = oidx_reg;
    assign res.last         = olast_reg;
    assign res.error        = oerr_reg;

    // checks
    `WG_ASSERT_IMP(a_err_shape, clk, rst_n, res.valid && res.error, res.last && res.sample_index == 6'd0 && res.sample_value == 32'sd0, "error transaction must be a lone zero sample")
    `WG_ASSERT_IMP(a_idx_range, clk, rst_n, state_reg != S_IDLE, i_reg < n_reg, "sample index ran past the count")
    `WG_ASSERT_IMP(a_div_free, clk, rst_n, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `WG_ASSERT_NEXT(a_busy_after, clk, rst_n, req.valid && req.ready && !(req.req_type == KIND_RICKER && req.norm_mode == NORM_AREA), !req.ready, "request channel open during work")
endmodule

### bench/wavelet_checker.sv
// watches both channels of the wavelet generator, predicts every sample and compares
`timescale 1ns / 100ps

module wavelet_checker
    import wg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    wg_req_if    req,
    wg_res_if    res,
    output int   fail_count,
    output int   pending
);

    localparam int STORE_DEPTH = 64;
    localparam longint unsigned MASK40 = 64'hFF_FFFF_FFFF;

    typedef struct packed {
        logic signed [31:0] value;
        logic [5:0]         index;
        logic               last;
        logic               error;
    } sample_t;

    sample_t expected_samples[$];
    logic signed [31:0] wave_store[STORE_DEPTH];

    // exp(-x), x in Q.32, result Q1.30
    function automatic longint unsigned exp_q30(longint unsigned x);
        longint unsigned k, g, term, e;
        longint acc;
        if (x >= (64'd32 << 32))
            return 0;
        k = x >> 32;
        g = x & 64'hFFFF_FFFF;
        acc = 64'd1 << 30;
        term = 64'd1 << 30;
        for (int j = 1; j <= 12; j++)
        begin
            term = ((term * g) >> 32) / j;
            if (j % 2 == 1)
                acc = acc - longint'(term);
            else
                acc = acc + longint'(term);
        end
        if (acc < 0)
            acc = 0;
        if (acc > (64'sd1 << 30))
            acc = 64'sd1 << 30;
        e = longint'(acc);
        while (k > 0)
        begin
            e = (e * 64'(EINV_Q30) + (64'd1 << 29)) >> 30;
            k--;
        end
        return e;
    endfunction

    function automatic logic signed [31:0] gauss_at(longint unsigned tt, longint unsigned sigma);
        longint unsigned r;
        if (sigma == 0)
        begin
            if (tt != 0)
                return 0;
            r = 0;
        end
        else
            r = (tt << 23) / sigma;
        if (r >= (64'd6 << 24))
            return 0;
        return 32'(exp_q30((r * r) >> 16));
    endfunction

    function automatic logic signed [31:0] ricker_at(longint unsigned tt, longint unsigned nu);
        longint unsigned hi, lo, v, u, a, e, m, mag;
        longint f;
        hi = tt * (nu >> 16);
        lo = tt * (nu & 64'hFFFF);
        v = (hi >> 1) + ((((hi & 1) << 16) + lo) >> 17);
        if (v >= (64'd16 << 32))
            return 0;
        u = ((v >> 8) * 64'(PI_Q30)) >> 30;
        a = (u * u) >> 16;
        e = exp_q30(a);
        if (e == 0)
            return 0;
        f = (64'sd1 <<< 32) - longint'(2 * a);
        m = (f < 0) ? longint'(-f) : longint'(f);
        mag = ((m >> 8) * e) >> 24;
        return (f < 0) ? -32'(mag) : 32'(mag);
    endfunction

    // signed q30 quotient, saturated
    function automatic logic signed [31:0] ratio_q30(longint num, longint den);
        logic neg;
        longint unsigned an, ad, q;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        if (an == 0)
            return 0;
        if (ad == 0)
            return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        q = (an << 30) / ad;
        if (neg)
            return (q >= 64'd2147483648) ? 32'sh8000_0000 : -32'(q);
        return (q >= 64'd2147483647) ? 32'sh7FFF_FFFF : 32'(q);
    endfunction

    // expected samples of one request
    task automatic predict_wavelet(logic kind, logic [6:0] count, longint unsigned dt,
                                   longint unsigned width, norm_mode_t mode_in);
        int n;
        norm_mode_t mode;
        longint unsigned sum, tt;
        longint k2, norm;
        sample_t s;
        n = (count == 0) ? 1 : ((count > STORE_DEPTH) ? STORE_DEPTH : int'(count));
        mode = (mode_in == NORM_RSVD) ? NORM_NONE : mode_in;
        if (kind == KIND_RICKER && mode == NORM_AREA)
        begin
            s = '{value: 0, index: 0, last: 1'b1, error: 1'b1};
            expected_samples.push_back(s);
            return;
        end
        sum = 0;
        for (int i = 0; i < n; i++)
        begin
            k2 = 2 * i - (n - 1);
            tt = ((k2 < 0) ? -k2 : k2) * dt;
            wave_store[i] = (kind == KIND_RICKER) ? ricker_at(tt, width) : gauss_at(tt, width);
            if (kind == KIND_GAUSS)
                sum = (sum + longint'(wave_store[i])) & MASK40;
        end
        norm = (mode == NORM_PEAK) ? longint'(wave_store[n >> 1]) : longint'(sum);
        for (int i = 0; i < n; i++)
        begin
            s.value = (mode == NORM_NONE) ? wave_store[i] : ratio_q30(wave_store[i], norm);
            s.index = 6'(i);
            s.last = (i == n - 1);
            s.error = 1'b0;
            expected_samples.push_back(s);
        end
    endtask

    task automatic report(string what, longint got, longint want);
        $display("%0t mismatch on %s: got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
    end

    assign pending = expected_samples.size();

    // request transactions feed the predictor
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            predict_wavelet(req.req_type, req.sample_count, req.sample_interval,
                            req.shape_width, norm_mode_t'(req.norm_mode));
    end

    // result transactions against the oldest expectation
    always @(posedge clk)
    begin : compare_block
        sample_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (expected_samples.size() == 0)
                report("unexpected result index", res.sample_index, -1);
            else
            begin
                want = expected_samples.pop_front();
                if (res.sample_value !== want.value)
                    report("sample_value", res.sample_value, want.value);
                if (res.sample_index !== want.index)
                    report("sample_index", res.sample_index, want.index);
                if (res.last !== want.last)
                    report("last", res.last, want.last);
                if (res.error !== want.error)
                    report("error", res.error, want.error);
            end
        end
    end

endmodule

### bench/testbench.sv
// stimulus and verdict for the wavelet generator
`timescale 1ns / 100ps

module testbench;
    import wg_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   results_taken;
    logic quiet;

    wg_req_if req_ch ();
    wg_res_if res_ch ();

    wavelet_generator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    wavelet_checker checker_inst (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // one request transaction, with a random gap ahead of it
    task automatic send_request(logic kind, logic [6:0] count, logic [31:0] dt,
                                logic [31:0] width, norm_mode_t mode);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.sample_count <= count;
        req_ch.sample_interval <= dt;
        req_ch.shape_width <= width;
        req_ch.norm_mode <= mode;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // receiver: random stalls, one long hold to back up the block
    initial
    begin : receiver
        int stall;
        res_ch.ready = 1'b0;
        results_taken = 0;
        @(posedge rst_n);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 11);
            if (results_taken == 40)
                stall = 4000;
            if (stall > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
            results_taken++;
        end
    end

    // watchdog
    initial
    begin
        #300ms;
        $display("wavelet_generator verification failed");
        $finish;
    end

    // stimulus and verdict
    initial
    begin : stimulus
        logic [6:0]  count;
        logic [31:0] dt;
        logic [31:0] width;
        logic        kind;
        quiet = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.req_type = KIND_GAUSS;
        req_ch.sample_count = '0;
        req_ch.sample_interval = '0;
        req_ch.shape_width = '0;
        req_ch.norm_mode = NORM_NONE;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corners
        send_request(KIND_GAUSS, 7'd1, 32'd1, 32'd0, NORM_NONE);
        send_request(KIND_GAUSS, 7'd0, 32'h0100_0000, 32'h0100_0000, NORM_PEAK);
        send_request(KIND_GAUSS, 7'd5, 32'h0040_0000, 32'd0, NORM_PEAK);
        send_request(KIND_GAUSS, 7'd4, 32'h0040_0000, 32'd0, NORM_AREA);
        send_request(KIND_GAUSS, 7'd9, 32'h0020_0000, 32'h0080_0000, NORM_AREA);
        send_request(KIND_GAUSS, 7'd7, 32'h0020_0000, 32'h0080_0000, NORM_RSVD);
        send_request(KIND_GAUSS, 7'd64, 32'h0008_0000, 32'h0100_0000, NORM_PEAK);
        send_request(KIND_GAUSS, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NORM_AREA);
        send_request(KIND_GAUSS, 7'd3, 32'hFFFF_FFFF, 32'd1, NORM_NONE);
        send_request(KIND_GAUSS, 7'd6, 32'd1, 32'hFFFF_FFFF, NORM_PEAK);
        send_request(KIND_RICKER, 7'd5, 32'h0010_0000, 32'h0200_0000, NORM_AREA);
        send_request(KIND_RICKER, 7'd1, 32'h0010_0000, 32'h0200_0000, NORM_AREA);
        send_request(KIND_RICKER, 7'd6, 32'h0010_0000, 32'd0, NORM_NONE);
        send_request(KIND_RICKER, 7'd9, 32'h0004_0000, 32'h1900_0000, NORM_NONE);
        send_request(KIND_RICKER, 7'd9, 32'h0004_0000, 32'h1900_0000, NORM_PEAK);
        send_request(KIND_RICKER, 7'd8, 32'h0004_0000, 32'h1900_0000, NORM_PEAK);
        send_request(KIND_RICKER, 7'd4, 32'h0004_0000, 32'h1900_0000, NORM_RSVD);
        send_request(KIND_RICKER, 7'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, NORM_NONE);
        send_request(KIND_RICKER, 7'd64, 32'h0001_0000, 32'h0A00_0000, NORM_PEAK);
        send_request(KIND_RICKER, 7'd127, 32'd1, 32'd1, NORM_NONE);

        // random requests, mostly short with shapes that give nonzero samples
        for (int item = 0; item < 240; item++)
        begin
            quiet = (item % 60) >= 45;
            kind = $urandom_range(0, 1);
            count = ($urandom_range(0, 9) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(1, 8));
            if ($urandom_range(0, 7) == 0)
            begin
                dt = $urandom;
                width = $urandom;
            end
            else
            begin
                dt = $urandom_range(1, 32'h0040_0000);
                width = (kind == KIND_RICKER) ? $urandom_range(32'h0040_0000, 32'h0400_0000)
                                              : $urandom_range(32'h0010_0000, 32'h0400_0000);
            end
            send_request(kind, count, dt, width, norm_mode_t'($urandom_range(0, 3)));
        end
        req_ch.valid <= 1'b0;

        // drain
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("wavelet_generator verification clean");
        else
            $display("wavelet_generator verification failed");
        $finish;
    end

endmodule

### wavelet_generator.f
+incdir+design
design/wg_pkg.sv
design/wg_req_if.sv
design/wg_res_if.sv
design/wg_mul.sv
design/wg_div.sv
design/wavelet_generator.sv
bench/wavelet_checker.sv
bench/testbench.sv
